[rtl/core/etss_pkg.sv]
`default_nettype none
package etss_pkg;

  localparam int TableDepth = 1024;
  localparam int VertexBits = 32;
  localparam int IdxBits = 10;
  localparam int CntBits = 11;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_SORT   = 3'd1,
    CMD_READ   = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_SRC  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SORT_NONE = 2'd0,
    SORT_SRC  = 2'd1,
    SORT_DST  = 2'd2
  } sorted_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SRCH_FIN,
    S_SRCH_WAIT,
    S_SORT_OUT,
    S_SORT_KEY,
    S_SORT_CMP,
    S_SORT_FIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]            command;
    logic [VertexBits-1:0] src_vertex;
    logic [VertexBits-1:0] dst_vertex;
    logic [IdxBits-1:0]    read_index;
    logic [VertexBits-1:0] search_vertex;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [VertexBits-1:0] out_src;
    logic [VertexBits-1:0] out_dst;
    logic [CntBits-1:0]    out_index;
    logic [CntBits-1:0]    out_count;
  } out_item_t;

  // Memory access request from the sequencer.
  typedef struct packed {
    logic               we;
    logic [IdxBits-1:0] waddr;
    logic [63:0]        wdata;
    logic [IdxBits-1:0] raddr;
  } mem_req_t;

  // Lexicographic key: by destination swaps the halves.
  function automatic logic [63:0] sort_key(logic [63:0] e, logic by_dst);
    sort_key = by_dst ? {e[31:0], e[63:32]} : e;
  endfunction

endpackage
`default_nettype wire

[rtl/core/etss_store.sv]
`default_nettype none
module etss_store (
  input  wire logic              clk,
  input  wire etss_pkg::mem_req_t req,
  output logic [63:0]            rdata
);

  logic [63:0] mem [etss_pkg::TableDepth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

[rtl/core/edge_table_sort_and_search.sv]
// Append, clear and unknown commands go straight to S_DONE; read waits in S_RD_WAIT;
// search loops S_SRCH_RD and S_SRCH_CMP per halving step, then S_SRCH_FIN, S_SRCH_WAIT;
// sort is an insertion sort through the edge memory, one write and one read port.
// Throughput: one transaction at a time; in_ready is low while one is in work.
// Reset (synchronous, rst high) empties the table, marks it unsorted and sets
// sort_order to 0; edge memory contents are not cleared.
`default_nettype none
module edge_table_sort_and_search (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire etss_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output etss_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data
);

  etss_pkg::state_t  state, state_next;
  etss_pkg::in_item_t item;
  etss_pkg::sorted_t sorted;
  etss_pkg::mem_req_t req;
  etss_pkg::out_item_t accept_result;
  logic [63:0] rdata;
  logic        sort_order;
  logic [10:0] count;
  // Sort and search registers.
  logic [10:0] i_idx, j_idx, lo, hi;
  logic [63:0] cur;
  logic        by_dst;
  logic        out_full;
  logic [10:0] mid;
  logic [63:0] cur_key, prev_key;
  logic        prev_gt;

  assign mid      = lo + ((hi - lo) >> 1);
  assign cur_key  = etss_pkg::sort_key(cur, by_dst);
  assign prev_key = etss_pkg::sort_key(rdata, by_dst);
  assign prev_gt  = prev_key > cur_key;

  assign in_ready  = (state == etss_pkg::S_IDLE) && !out_full;
  assign out_valid = out_full;
  assign cfg_ready = 1'b1;

  etss_store u_store (.clk(clk), .req(req), .rdata(rdata));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      etss_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          priority case (in_data.command)
            etss_pkg::CMD_READ:
              state_next = (11'(in_data.read_index) < count) ?
                           etss_pkg::S_RD_WAIT : etss_pkg::S_DONE;
            etss_pkg::CMD_SEARCH:
              state_next = (sorted == etss_pkg::SORT_SRC) ?
                           etss_pkg::S_SRCH_RD : etss_pkg::S_DONE;
            etss_pkg::CMD_SORT: state_next = etss_pkg::S_SORT_OUT;
            default:            state_next = etss_pkg::S_DONE;
          endcase
        end
      end
      etss_pkg::S_RD_WAIT:   state_next = etss_pkg::S_DONE;
      etss_pkg::S_SRCH_RD:
        state_next = (lo < hi) ? etss_pkg::S_SRCH_CMP : etss_pkg::S_SRCH_FIN;
      etss_pkg::S_SRCH_CMP:  state_next = etss_pkg::S_SRCH_RD;
      etss_pkg::S_SRCH_FIN:  state_next = etss_pkg::S_SRCH_WAIT;
      etss_pkg::S_SRCH_WAIT: state_next = etss_pkg::S_DONE;
      etss_pkg::S_SORT_OUT:
        state_next = (i_idx < count) ? etss_pkg::S_SORT_KEY : etss_pkg::S_DONE;
      etss_pkg::S_SORT_KEY:  state_next = etss_pkg::S_SORT_CMP;
      etss_pkg::S_SORT_CMP:
        state_next = (j_idx != 11'd0) ? etss_pkg::S_SORT_FIN : etss_pkg::S_SORT_OUT;
      etss_pkg::S_SORT_FIN:
        state_next = prev_gt ? etss_pkg::S_SORT_CMP : etss_pkg::S_SORT_OUT;
      etss_pkg::S_DONE:      state_next = etss_pkg::S_IDLE;
      default:               state_next = etss_pkg::S_IDLE;
    endcase
  end

  // Memory port drive.
  always_comb begin
    req = '0;
    unique case (state)
      etss_pkg::S_IDLE: begin
        req.raddr = in_data.read_index;
        if (in_valid && in_ready && in_data.command == etss_pkg::CMD_APPEND &&
            count < 11'(etss_pkg::TableDepth)) begin
          req.we    = 1'b1;
          req.waddr = count[9:0];
          req.wdata = {in_data.src_vertex, in_data.dst_vertex};
        end
      end
      etss_pkg::S_SRCH_RD:  req.raddr = mid[9:0];
      etss_pkg::S_SRCH_FIN: req.raddr = lo[9:0];
      etss_pkg::S_SORT_OUT: req.raddr = i_idx[9:0];
      etss_pkg::S_SORT_CMP: req.raddr = j_idx[9:0] - 10'd1;
      etss_pkg::S_SORT_FIN: begin
        // Shift the larger neighbor up, or drop the held edge into place.
        req.we    = 1'b1;
        req.waddr = j_idx[9:0];
        req.wdata = prev_gt ? rdata : cur;
      end
      default: req.raddr = '0;
    endcase
    if (state == etss_pkg::S_SORT_CMP && j_idx == 11'd0) begin
      req.we    = 1'b1;
      req.waddr = '0;
      req.wdata = cur;
    end
  end

  // Result fields that are already known when a transaction is accepted.
  always_comb begin
    accept_result = '0;
    unique case (in_data.command)
      etss_pkg::CMD_APPEND: begin
        if (count < 11'(etss_pkg::TableDepth)) begin
          accept_result.out_index = count;
        end else begin
          accept_result.status = etss_pkg::ST_FULL;
        end
      end
      etss_pkg::CMD_READ: begin
        if (11'(in_data.read_index) >= count) begin
          accept_result.status = etss_pkg::ST_RANGE;
        end
      end
      etss_pkg::CMD_SEARCH: begin
        if (sorted != etss_pkg::SORT_SRC) begin
          accept_result.status = etss_pkg::ST_NOT_SRC;
        end
      end
      default: ;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= etss_pkg::S_IDLE;
      count      <= '0;
      sorted     <= etss_pkg::SORT_NONE;
      sort_order <= 1'b0;
      out_full   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        sort_order <= cfg_data;
      end
      if (out_full && out_ready) begin
        out_full <= 1'b0;
      end
      unique case (state)
        etss_pkg::S_IDLE: begin
          if (in_valid && in_ready) begin
            item              <= in_data;
            out_data          <= accept_result;
            by_dst            <= sort_order;
            i_idx             <= 11'd1;
            lo                <= '0;
            hi                <= count;
            unique case (in_data.command)
              etss_pkg::CMD_APPEND: begin
                if (count < 11'(etss_pkg::TableDepth)) begin
                  count  <= count + 11'd1;
                  sorted <= etss_pkg::SORT_NONE;
                end
              end
              etss_pkg::CMD_CLEAR: begin
                count  <= '0;
                sorted <= etss_pkg::SORT_NONE;
              end
              default: ;
            endcase
          end
        end
        etss_pkg::S_RD_WAIT: begin
          out_data.out_src   <= rdata[63:32];
          out_data.out_dst   <= rdata[31:0];
          out_data.out_index <= 11'(item.read_index);
        end
        etss_pkg::S_SRCH_CMP: begin
          if (rdata[63:32] < item.search_vertex) begin
            lo <= mid + 11'd1;
          end else begin
            hi <= mid;
          end
        end
        etss_pkg::S_SRCH_WAIT: begin
          out_data.out_index <= lo;
          if (lo < count) begin
            out_data.out_src <= rdata[63:32];
            out_data.out_dst <= rdata[31:0];
          end
        end
        etss_pkg::S_SORT_OUT: begin
          j_idx <= i_idx;
          if (i_idx >= count) begin
            sorted <= by_dst ? etss_pkg::SORT_DST : etss_pkg::SORT_SRC;
          end
        end
        etss_pkg::S_SORT_KEY: begin
          cur   <= rdata;
          i_idx <= i_idx + 11'd1;
        end
        etss_pkg::S_SORT_FIN: begin
          if (prev_gt) begin
            j_idx <= j_idx - 11'd1;
          end
        end
        etss_pkg::S_DONE: begin
          out_full           <= 1'b1;
          out_data.out_count <= count;
        end
        default: ;
      endcase
    end
  end

  // The table never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 11'(etss_pkg::TableDepth)) else $error("count overflow");
  // A new transaction is never taken while a result waits.
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    out_full |-> !in_ready) else $error("accept while result pending");
  // Search bounds stay ordered.
  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == etss_pkg::S_SRCH_RD) |-> (lo <= hi && hi <= count))
    else $error("search bounds");
  // Each completed command raises the result valid next cycle.
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    (state == etss_pkg::S_DONE) |=> out_valid) else $error("missing result");

endmodule
`default_nettype wire
